// File: rtl/shared_pool_ownership_directory_unit_assert.svh
// ----------------------------------------------------------------------------
// shared pool ownership directory: assertion macros
// clocked property checks with and without a reset guard
// ----------------------------------------------------------------------------
`ifndef SHARED_POOL_OWNERSHIP_DIRECTORY_UNIT_ASSERT_SVH
`define SHARED_POOL_OWNERSHIP_DIRECTORY_UNIT_ASSERT_SVH

// property checked while reset is released
`define SPODU_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// property checked at every edge, reset included
`define SPODU_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/spodu_pkg.sv
// ----------------------------------------------------------------------------
// spodu_pkg
// types and constants shared by the shared pool ownership directory
// ----------------------------------------------------------------------------
package spodu_pkg;

  localparam int unsigned SIZE_W     = 21;
  localparam int unsigned ALOG_W     = 5;
  localparam int unsigned NODE_W     = 3;
  localparam int unsigned OFF_W      = 32;
  localparam int unsigned IDX_OUT_W  = 6;
  localparam int unsigned POOL_W     = 25;
  localparam int unsigned NCNT_W     = 4;
  localparam int unsigned CFG_W      = 25;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned MAX_COPIES = 64;
  localparam int unsigned COPY_CNT_W = 7;
  localparam int unsigned CMD_DEPTH  = 2;
  localparam int unsigned RES_DEPTH  = 2;

  localparam logic [NCNT_W-1:0] SHARE_NODES_RST = 4'd2;
  localparam logic [POOL_W-1:0] POOL_SIZE_RST   = 25'd1048576;
  localparam logic              SHARED_EN_RST   = 1'b1;

  typedef enum logic {
    OP_ALLOC,
    OP_LINK
  } op_e;

  typedef enum logic [1:0] {
    KIND_ALLOC,
    KIND_FAIL,
    KIND_COPY,
    KIND_DONE
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHARE_NODES,
    CFG_POOL_SIZE,
    CFG_SHARED_ENABLE
  } cfg_idx_e;

  typedef struct packed {
    logic [NCNT_W-1:0] share_nodes;
    logic [POOL_W-1:0] pool_size;
    logic              shared_enable;
  } cfg_t;

  typedef struct packed {
    op_e               op;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  low_mask;
    logic [NODE_W-1:0] node;
  } cmd_t;

  typedef struct packed {
    kind_e                kind;
    logic [OFF_W-1:0]     offset;
    logic [IDX_OUT_W-1:0] index;
    logic [NODE_W-1:0]    src;
    logic [NODE_W-1:0]    dst;
    logic [SIZE_W-1:0]    length;
    logic                 last;
  } res_t;

endpackage

// File: rtl/spodu_fifo.sv
// ----------------------------------------------------------------------------
// spodu_fifo
// small synchronous queue, register storage, first-word fall-through
// ----------------------------------------------------------------------------
module spodu_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  T                 mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/spodu_front.sv
// ----------------------------------------------------------------------------
// spodu_front
// takes requests, decodes the alignment mask and queues them for the engine
// ----------------------------------------------------------------------------
module spodu_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        op_i,
  input  logic [spodu_pkg::SIZE_W-1:0] size_i,
  input  logic [spodu_pkg::ALOG_W-1:0] align_log2_i,
  input  logic [spodu_pkg::NODE_W-1:0] node_i,
  input  logic                        cmd_pop_i,
  output spodu_pkg::cmd_t             cmd_o,
  output logic                        cmd_empty_o
);

  import spodu_pkg::*;

  cmd_t cmd_in;

  always_comb begin
    cmd_in.op       = op_e'(op_i);
    cmd_in.size     = size_i;
    cmd_in.low_mask = (OFF_W'(1) << align_log2_i) - OFF_W'(1);
    cmd_in.node     = node_i;
  end

  spodu_fifo #(
    .DEPTH (CMD_DEPTH),
    .T     (cmd_t)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty_o)
  );

endmodule

// File: rtl/spodu_back.sv
// ----------------------------------------------------------------------------
// spodu_back
// allocation and link engine over the ownership table
// ----------------------------------------------------------------------------
`include "shared_pool_ownership_directory_unit_assert.svh"

module spodu_back #(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned NODES   = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spodu_pkg::cfg_t cfg_i,
  input  spodu_pkg::cmd_t cmd_i,
  input  logic            cmd_empty_i,
  output logic            cmd_pop_o,
  input  logic            res_full_i,
  output logic            res_push_o,
  output spodu_pkg::res_t res_o
);

  import spodu_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_WALK,
    S_FLUSH
  } state_e;

  state_e                state_q;
  logic [OFF_W-1:0]      bp_q;
  logic [CNT_W-1:0]      used_q;
  logic [CNT_W-1:0]      rd_idx_q;
  logic                  vld_q;
  logic                  pend_vld_q;
  logic [COPY_CNT_W-1:0] cnt_q;

  logic [OFF_W-1:0]      base_q;
  logic [SIZE_W-1:0]     size_q;
  logic [NODE_W-1:0]     node_q;
  logic [NODES-1:0]      bit_q;
  logic [IDX_W-1:0]      ev_idx_q;
  res_t                  pend_q;

  logic [OFF_W-1:0]      off_mem [ENTRIES];
  logic [SIZE_W-1:0]     len_mem [ENTRIES];
  logic [NODES-1:0]      mask_mem [ENTRIES];
  logic [OFF_W-1:0]      rd_off_q;
  logic [SIZE_W-1:0]     rd_len_q;
  logic [NODES-1:0]      rd_mask_q;

  logic                  table_full, more, found, emit, stall, walk_adv;
  logic                  go_alloc, go_walk, overrun;
  logic [NODE_W-1:0]     src;
  logic [NODES-1:0]      node_bit;
  logic [OFF_W-1:0]      bp_new;
  logic                  alloc_we, mask_we, rd_en;
  logic [IDX_W-1:0]      mask_waddr;
  logic [NODES-1:0]      mask_wdata;
  res_t                  res;

  assign table_full = (used_q == CNT_W'(ENTRIES));
  assign more       = (rd_idx_q != used_q);
  assign bp_new     = base_q + OFF_W'(size_q);
  assign overrun    = (bp_new > OFF_W'(cfg_i.pool_size));

  // lowest owner below the active node count
  always_comb begin
    found = 1'b0;
    src   = '0;
    for (int s = NODES - 1; s >= 0; s--) begin
      if (rd_mask_q[s] && (NCNT_W'(s) < cfg_i.share_nodes)) begin
        found = 1'b1;
        src   = NODE_W'(s);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < NODES; j++) begin
      node_bit[j] = (cmd_i.node == NODE_W'(j));
    end
  end

  assign emit  = (rd_mask_q != '0) && ((rd_mask_q & bit_q) == '0) && found &&
                 (cnt_q < COPY_CNT_W'(MAX_COPIES));
  assign stall = vld_q && emit && pend_vld_q && res_full_i;

  always_comb begin
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res        = '0;
    alloc_we   = 1'b0;
    mask_we    = 1'b0;
    mask_waddr = ev_idx_q;
    mask_wdata = bit_q;
    rd_en      = 1'b0;
    walk_adv   = 1'b0;
    go_alloc   = 1'b0;
    go_walk    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          if (cmd_i.op == OP_ALLOC) begin
            if (!cfg_i.shared_enable || table_full) begin
              if (!res_full_i) begin
                res_push_o = 1'b1;
                res.kind   = KIND_FAIL;
                res.last   = 1'b1;
                cmd_pop_o  = 1'b1;
              end
            end else begin
              cmd_pop_o = 1'b1;
              go_alloc  = 1'b1;
            end
          end else begin
            cmd_pop_o = 1'b1;
            go_walk   = 1'b1;
          end
        end
      end
      S_ALLOC: begin
        if (!res_full_i) begin
          alloc_we   = 1'b1;
          mask_we    = 1'b1;
          mask_waddr = used_q[IDX_W-1:0];
          mask_wdata = '0;
          res_push_o = 1'b1;
          res.last   = 1'b1;
          if (overrun) begin
            res.kind = KIND_FAIL;
          end else begin
            res.kind   = KIND_ALLOC;
            res.offset = base_q;
            res.index  = IDX_OUT_W'(used_q);
            res.length = size_q;
          end
        end
      end
      S_WALK: begin
        walk_adv = !stall;
        if (walk_adv) begin
          mask_we = vld_q;
          rd_en   = more;
          if (vld_q && emit && pend_vld_q) begin
            res_push_o = 1'b1;
            res        = pend_q;
          end
        end
      end
      S_FLUSH: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (pend_vld_q) begin
            res = pend_q;
          end else begin
            res.kind = KIND_DONE;
            res.dst  = node_q;
          end
          res.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      bp_q       <= '0;
      used_q     <= '0;
      rd_idx_q   <= '0;
      vld_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (go_alloc) begin
            state_q <= S_ALLOC;
          end else if (go_walk) begin
            rd_idx_q   <= '0;
            vld_q      <= 1'b0;
            pend_vld_q <= 1'b0;
            cnt_q      <= '0;
            state_q    <= S_WALK;
          end
        end
        S_ALLOC: begin
          if (!res_full_i) begin
            bp_q <= bp_new;
            if (!overrun) begin
              used_q <= used_q + CNT_W'(1);
            end
            state_q <= S_IDLE;
          end
        end
        S_WALK: begin
          if (walk_adv) begin
            if (vld_q && emit) begin
              pend_vld_q <= 1'b1;
              cnt_q      <= cnt_q + COPY_CNT_W'(1);
            end
            if (more) begin
              rd_idx_q <= rd_idx_q + CNT_W'(1);
              vld_q    <= 1'b1;
            end else begin
              vld_q   <= 1'b0;
              state_q <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          if (!res_full_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_alloc) begin
      base_q <= (bp_q + cmd_i.low_mask) & ~cmd_i.low_mask;
      size_q <= cmd_i.size;
    end
    if (go_walk) begin
      node_q <= cmd_i.node;
      bit_q  <= node_bit;
    end
    if (walk_adv && more) begin
      ev_idx_q <= rd_idx_q[IDX_W-1:0];
    end
    if (walk_adv && vld_q && emit) begin
      pend_q.kind   <= KIND_COPY;
      pend_q.offset <= rd_off_q;
      pend_q.index  <= IDX_OUT_W'(ev_idx_q);
      pend_q.src    <= src;
      pend_q.dst    <= node_q;
      pend_q.length <= rd_len_q;
      pend_q.last   <= 1'b0;
    end
  end

  // ownership table
  always_ff @(posedge clk_i) begin
    if (alloc_we) begin
      off_mem[used_q[IDX_W-1:0]] <= base_q;
      len_mem[used_q[IDX_W-1:0]] <= size_q;
    end
    if (mask_we) begin
      mask_mem[mask_waddr] <= mask_wdata;
    end
    if (rd_en) begin
      rd_off_q  <= off_mem[rd_idx_q[IDX_W-1:0]];
      rd_len_q  <= len_mem[rd_idx_q[IDX_W-1:0]];
      rd_mask_q <= mask_mem[rd_idx_q[IDX_W-1:0]];
    end
  end

  `SPODU_ASSERT(a_used_bound, clk_i, rst_ni, used_q <= CNT_W'(ENTRIES), "entry count past table")
  `SPODU_ASSERT(a_push_space, clk_i, rst_ni, res_push_o |-> !res_full_i, "result push while full")
  `SPODU_ASSERT(a_rd_bound, clk_i, rst_ni, rd_idx_q <= used_q, "walk index past used entries")
  `SPODU_ASSERT(a_vld_walk, clk_i, rst_ni, vld_q |-> (state_q == S_WALK), "read data outside walk")
  `SPODU_ASSERT(a_pop_idle, clk_i, rst_ni, cmd_pop_o |-> (state_q == S_IDLE), "request taken while busy")

endmodule

// File: rtl/shared_pool_ownership_directory_unit.sv
// ----------------------------------------------------------------------------
// shared_pool_ownership_directory_unit
// allocate: taken in idle, then the alloc state writes the table entry and pushes the result
// failed allocate with sharing off or a full table: result pushed from idle as the request is taken
// link: walks the used entries through the one-port table read, stalls on a full result queue, then flushes
// requests queue 2 deep ahead of the engine, results 2 deep behind it
// reset: pointer and entry count cleared, registers to defaults, table undefined
// ----------------------------------------------------------------------------
module shared_pool_ownership_directory_unit #(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned NODES   = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic                            op_i,
  input  logic [spodu_pkg::SIZE_W-1:0]    size_i,
  input  logic [spodu_pkg::ALOG_W-1:0]    align_log2_i,
  input  logic [spodu_pkg::NODE_W-1:0]    node_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [1:0]                      kind_o,
  output logic [spodu_pkg::OFF_W-1:0]     offset_o,
  output logic [spodu_pkg::IDX_OUT_W-1:0] entry_index_o,
  output logic [spodu_pkg::NODE_W-1:0]    source_node_o,
  output logic [spodu_pkg::NODE_W-1:0]    dest_node_o,
  output logic [spodu_pkg::SIZE_W-1:0]    length_o,
  output logic                            last_o,
  input  logic                            cfg_we_i,
  input  logic [spodu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [spodu_pkg::CFG_W-1:0]     cfg_data_i
);

  import spodu_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  res_t res_in, res_out;
  logic cmd_empty, cmd_pop, res_full, res_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.share_nodes   <= SHARE_NODES_RST;
      cfg_q.pool_size     <= POOL_SIZE_RST;
      cfg_q.shared_enable <= SHARED_EN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SHARE_NODES:   cfg_q.share_nodes   <= cfg_data_i[NCNT_W-1:0];
        CFG_POOL_SIZE:     cfg_q.pool_size     <= cfg_data_i[POOL_W-1:0];
        CFG_SHARED_ENABLE: cfg_q.shared_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  spodu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .op_i         (op_i),
    .size_i       (size_i),
    .align_log2_i (align_log2_i),
    .node_i       (node_i),
    .cmd_pop_i    (cmd_pop),
    .cmd_o        (cmd),
    .cmd_empty_o  (cmd_empty)
  );

  spodu_back #(
    .ENTRIES (ENTRIES),
    .NODES   (NODES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  spodu_fifo #(
    .DEPTH (RES_DEPTH),
    .T     (res_t)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign kind_o        = res_out.kind;
  assign offset_o      = res_out.offset;
  assign entry_index_o = res_out.index;
  assign source_node_o = res_out.src;
  assign dest_node_o   = res_out.dst;
  assign length_o      = res_out.length;
  assign last_o        = res_out.last;

endmodule

// File: tb/tb_shared_pool_ownership_directory_unit.sv
// ----------------------------------------------------------------------------
// tb_shared_pool_ownership_directory_unit
// Drives allocate and link requests into the directory through its queue-like
// ports and holds its own model of the bump allocator and owner masks. Every
// popped result is compared field by field against the oldest predicted one.
// The run walks through several register settings: defaults, sharing off,
// widest pool with all nodes, empty pool with no sharing nodes, a full table
// with node counts above the node limit, and a single node without idling.
// ----------------------------------------------------------------------------
module tb_shared_pool_ownership_directory_unit;

  import spodu_pkg::*;

  localparam int unsigned ENTRIES   = 64;
  localparam int unsigned NODES     = 8;
  localparam int unsigned SETTLE    = 80;
  localparam int unsigned MAX_CYCLE = 600000;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  typedef struct {
    op_e               op;
    logic [SIZE_W-1:0] size;
    logic [ALOG_W-1:0] align_log2;
    logic [NODE_W-1:0] node;
  } request_t;

  class pool_directory_scoreboard;
    logic [NCNT_W-1:0] share_nodes;
    logic [POOL_W-1:0] pool_size;
    logic              shared_enable;
    logic [OFF_W-1:0]  bump_ptr;
    int unsigned       entries_used;
    logic [OFF_W-1:0]  entry_offset [ENTRIES];
    logic [SIZE_W-1:0] entry_length [ENTRIES];
    logic [NODES-1:0]  owner_mask [ENTRIES];
    res_t              pending [$];
    int unsigned       errors;
    int unsigned       results_seen;

    function void clear();
      share_nodes   = SHARE_NODES_RST;
      pool_size     = POOL_SIZE_RST;
      shared_enable = SHARED_EN_RST;
      bump_ptr      = '0;
      entries_used  = 0;
      errors        = 0;
      results_seen  = 0;
      pending.delete();
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_SHARE_NODES:   share_nodes   = data[NCNT_W-1:0];
        CFG_POOL_SIZE:     pool_size     = data[POOL_W-1:0];
        CFG_SHARED_ENABLE: shared_enable = data[0];
        default: ;
      endcase
    endfunction

    function void note_request(request_t rq);
      logic [OFF_W-1:0] align;
      logic [OFF_W-1:0] base;
      logic [NODES-1:0] node_bit;
      int unsigned      limit;
      int unsigned      copies;
      res_t             r;
      r = '{kind: KIND_FAIL, offset: '0, index: '0, src: '0, dst: '0, length: '0,
            last: 1'b1};
      if (rq.op == OP_ALLOC) begin
        if (!shared_enable || entries_used >= ENTRIES) begin
          pending.push_back(r);
          return;
        end
        align = 32'd1 << rq.align_log2;
        base  = (bump_ptr + align - 32'd1) & ~(align - 32'd1);
        entry_offset[entries_used] = base;
        entry_length[entries_used] = rq.size;
        owner_mask[entries_used]   = '0;
        bump_ptr = base + 32'(rq.size);
        if (bump_ptr > 32'(pool_size)) begin
          pending.push_back(r);
          return;
        end
        r.kind   = KIND_ALLOC;
        r.offset = base;
        r.index  = entries_used[IDX_OUT_W-1:0];
        r.length = rq.size;
        pending.push_back(r);
        entries_used++;
      end else begin
        limit    = (share_nodes < NODES) ? share_nodes : NODES;
        node_bit = 8'd1 << rq.node;
        copies   = 0;
        for (int unsigned i = 0; i < entries_used; i++) begin
          if (owner_mask[i] != '0 && (owner_mask[i] & node_bit) == '0) begin
            for (int unsigned s = 0; s < limit; s++) begin
              if (owner_mask[i][s]) begin
                if (copies < MAX_COPIES) begin
                  r.kind   = KIND_COPY;
                  r.offset = entry_offset[i];
                  r.index  = i[IDX_OUT_W-1:0];
                  r.src    = s[NODE_W-1:0];
                  r.dst    = rq.node;
                  r.length = entry_length[i];
                  r.last   = 1'b0;
                  pending.push_back(r);
                  copies++;
                end
                break;
              end
            end
          end
          owner_mask[i] = node_bit;
        end
        if (copies == 0) begin
          r.kind = KIND_DONE;
          r.dst  = rq.node;
          pending.push_back(r);
        end else begin
          pending[$].last = 1'b1;
        end
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      results_seen++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display({"result %0d with nothing pending: kind %0d off %h idx %0d ",
                    "src %0d dst %0d len %0d last %0d"},
                   results_seen, got.kind, got.offset, got.index, got.src, got.dst,
                   got.length, got.last);
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind || got.offset !== want.offset || got.index !== want.index ||
          got.src !== want.src || got.dst !== want.dst || got.length !== want.length ||
          got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display({"result %0d expected: kind %0d off %h idx %0d src %0d dst %0d ",
                    "len %0d last %0d"},
                   results_seen, want.kind, want.offset, want.index, want.src, want.dst,
                   want.length, want.last);
          $display({"result %0d actual:   kind %0d off %h idx %0d src %0d dst %0d ",
                    "len %0d last %0d"},
                   results_seen, got.kind, got.offset, got.index, got.src, got.dst,
                   got.length, got.last);
        end
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  logic                 op_i;
  logic [SIZE_W-1:0]    size_i;
  logic [ALOG_W-1:0]    align_log2_i;
  logic [NODE_W-1:0]    node_i;
  logic                 empty;
  logic                 pop;
  logic [1:0]           kind_o;
  logic [OFF_W-1:0]     offset_o;
  logic [IDX_OUT_W-1:0] entry_index_o;
  logic [NODE_W-1:0]    source_node_o;
  logic [NODE_W-1:0]    dest_node_o;
  logic [SIZE_W-1:0]    length_o;
  logic                 last_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  pool_directory_scoreboard sb;
  logic                     idling_on;
  int unsigned              cycles;

  shared_pool_ownership_directory_unit #(
    .ENTRIES(ENTRIES),
    .NODES  (NODES)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .op_i         (op_i),
    .size_i       (size_i),
    .align_log2_i (align_log2_i),
    .node_i       (node_i),
    .empty        (empty),
    .pop          (pop),
    .kind_o       (kind_o),
    .offset_o     (offset_o),
    .entry_index_o(entry_index_o),
    .source_node_o(source_node_o),
    .dest_node_o  (dest_node_o),
    .length_o     (length_o),
    .last_o       (last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYCLE) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side with random stall bursts
  initial begin
    int unsigned hold;
    hold = 0;
    pop  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold == 0 && idling_on && $urandom_range(7, 0) == 0)
        hold = $urandom_range(3, 1);
      if (hold != 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk_i);
      if (pop && !empty)
        sb.check_result('{kind: kind_e'(kind_o), offset: offset_o, index: entry_index_o,
                          src: source_node_o, dst: dest_node_o, length: length_o,
                          last: last_o});
    end
  end

  task automatic pause_requests(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
  endtask

  task automatic send_request(input request_t rq);
    @(negedge clk_i);
    push         <= 1'b1;
    op_i         <= rq.op;
    size_i       <= rq.size;
    align_log2_i <= rq.align_log2;
    node_i       <= rq.node;
    do @(posedge clk_i); while (full);
    sb.note_request(rq);
  endtask

  task automatic send_alloc(input logic [SIZE_W-1:0] size, input logic [ALOG_W-1:0] alog);
    send_request('{op: OP_ALLOC, size: size, align_log2: alog, node: '0});
  endtask

  task automatic send_link(input logic [NODE_W-1:0] node);
    send_request('{op: OP_LINK, size: '0, align_log2: '0, node: node});
  endtask

  task automatic wait_drained();
    pause_requests(1);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_register(idx, data);
  endtask

  task automatic send_random(input int unsigned alloc_pct);
    request_t rq;
    rq.op   = ($urandom_range(99, 0) < alloc_pct) ? OP_ALLOC : OP_LINK;
    rq.node = NODE_W'($urandom_range(7, 0));
    case ($urandom_range(9, 0))
      0:       rq.size = SIZE_W'($urandom_range(21'h1FFFFF, 0));
      1:       rq.size = '0;
      default: rq.size = SIZE_W'($urandom_range(4095, 0));
    endcase
    case ($urandom_range(9, 0))
      0:       rq.align_log2 = 5'd31;
      1:       rq.align_log2 = ALOG_W'($urandom_range(31, 0));
      default: rq.align_log2 = ALOG_W'($urandom_range(8, 0));
    endcase
    // pointer past the pool: often wrap it back with the widest alignment
    if (sb.bump_ptr > 32'(sb.pool_size) && $urandom_range(1, 0) == 1) begin
      rq.size       = SIZE_W'($urandom_range(255, 1));
      rq.align_log2 = 5'd31;
    end
    if (idling_on && $urandom_range(5, 0) == 0)
      pause_requests($urandom_range(3, 1));
    if ($urandom_range(24, 0) == 0)
      wait_drained();
    send_request(rq);
  endtask

  task automatic run_random(input int unsigned n);
    repeat (n) send_random(sb.entries_used < ENTRIES ? 60 : 35);
  endtask

  task automatic fill_table();
    while (sb.entries_used < ENTRIES) begin
      if (sb.bump_ptr > 32'(sb.pool_size))
        send_alloc(21'd1, 5'd31);
      else
        send_alloc(SIZE_W'($urandom_range(2047, 0)), ALOG_W'($urandom_range(6, 0)));
    end
  endtask

  initial begin
    sb = new;
    sb.clear();
    cycles       = 0;
    idling_on    = 1'b1;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    push         = 1'b0;
    op_i         = 1'b0;
    size_i       = '0;
    align_log2_i = '0;
    node_i       = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // defaults: two nodes, 1 MiB pool
    send_link(3'd3);
    send_alloc(21'd0, 5'd0);
    send_alloc(21'd1, 5'd0);
    send_alloc(21'd100, 5'd16);
    send_alloc(21'd5, 5'd3);
    send_link(3'd0);
    send_link(3'd1);
    send_link(3'd1);
    send_link(3'd0);
    send_link(3'd5);
    // owner above the node count: no copy, mask still moves
    send_link(3'd7);
    send_link(3'd2);
    send_link(3'd1);
    // pool overrun, then wrap the pointer with the widest alignment
    send_alloc(21'h1FFFFF, 5'd0);
    send_alloc(21'd4, 5'd31);
    send_alloc(21'h1FF, 5'd31);
    // exact fit up to the pool end
    send_alloc(21'd1048064, 5'd9);
    send_alloc(21'd0, 5'd0);
    send_alloc(21'd1, 5'd0);
    send_alloc(21'd1, 5'd31);
    send_alloc(21'd16, 5'd31);
    send_link(3'd4);
    wait_idle();

    // sharing off
    write_register(CFG_SHARED_ENABLE, 25'd0);
    send_alloc(21'd8, 5'd2);
    send_alloc(21'h1FFFFF, 5'd31);
    send_link(3'd6);
    wait_idle();

    // all nodes, widest pool
    write_register(CFG_SHARE_NODES, 25'd8);
    write_register(CFG_POOL_SIZE, 25'h1FFFFFF);
    write_register(CFG_SHARED_ENABLE, 25'd1);
    write_register(CFG_UNMAPPED, 25'h1FFFFFF);
    run_random(50);
    wait_idle();

    // no sharing nodes, empty pool
    write_register(CFG_SHARE_NODES, 25'd0);
    write_register(CFG_POOL_SIZE, 25'd0);
    run_random(20);
    wait_idle();

    // node count beyond the node limit, table filled up
    write_register(CFG_SHARE_NODES, 25'd15);
    write_register(CFG_POOL_SIZE, 25'd16777216);
    fill_table();
    run_random(20);
    wait_idle();

    // single node, no idling
    write_register(CFG_SHARE_NODES, 25'd1);
    idling_on = 1'b0;
    run_random(20);

    wait_idle();
    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: shared_pool_ownership_directory_unit.f
+incdir+rtl
rtl/spodu_pkg.sv
rtl/spodu_fifo.sv
rtl/spodu_front.sv
rtl/spodu_back.sv
rtl/shared_pool_ownership_directory_unit.sv
tb/tb_shared_pool_ownership_directory_unit.sv
